// File: sv/dsup_pkg.sv
// shared types, codes and decode functions for the dns stamp parser
package dsup_pkg;

  // parser phase, one-hot
  typedef enum logic [12:0] {
    PH_SCHEME   = 13'd1,
    PH_PROTO    = 13'd2,
    PH_FLAGS    = 13'd4,
    PH_ADDR_LEN = 13'd8,
    PH_ADDR     = 13'd16,
    PH_PIN_LEN  = 13'd32,
    PH_PIN      = 13'd64,
    PH_HOST_LEN = 13'd128,
    PH_HOST     = 13'd256,
    PH_PATH_LEN = 13'd512,
    PH_PATH     = 13'd1024,
    PH_DONE     = 13'd2048,
    PH_FAIL     = 13'd4096
  } phase_t;

  // address split state, one-hot
  typedef enum logic [5:0] {
    AS_START   = 6'd1,
    AS_PLAIN   = 6'd2,
    AS_BRACKET = 6'd4,
    AS_AFTER   = 6'd8,
    AS_PORT    = 6'd16,
    AS_SKIP    = 6'd32
  } addr_state_t;

  // field tags
  localparam logic [2:0] TAG_FLAGS = 3'd0;
  localparam logic [2:0] TAG_HOST  = 3'd1;
  localparam logic [2:0] TAG_PORT  = 3'd2;
  localparam logic [2:0] TAG_PIN   = 3'd3;
  localparam logic [2:0] TAG_NAME  = 3'd4;
  localparam logic [2:0] TAG_PATH  = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SCHEME = 3'd1;
  localparam logic [2:0] ST_BAD_B64    = 3'd2;
  localparam logic [2:0] ST_NOT_DOH    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;
  localparam logic [2:0] ST_MANY_PINS  = 3'd5;

  localparam logic [7:0] PROTO_DOH     = 8'h02;
  localparam logic [7:0] CH_LBRACKET   = 8'h5b;
  localparam logic [7:0] CH_RBRACKET   = 8'h5d;
  localparam logic [7:0] CH_COLON      = 8'h3a;
  localparam logic [2:0] SCHEME_LAST   = 3'd6;
  localparam int         PIN_CNT_W     = 4;

  // parser state carried between characters
  typedef struct packed {
    phase_t                 phase;
    logic [2:0]             spos;
    logic [5:0]             bits6;      // last sextet decoded
    logic [1:0]             cm4;        // base64 characters modulo four
    logic [7:0]             rem;
    logic [PIN_CNT_W-1:0]   pins;
    logic                   more_pins;
    addr_state_t            asub;
    logic                   malf;
    logic [2:0]             err;
    logic [7:0]             held;
    logic                   held_v;
  } st_t;

  localparam st_t ST_RESET = '{
    phase: PH_SCHEME, spos: 3'd0, bits6: 6'd0, cm4: 2'd0, rem: 8'd0,
    pins: '0, more_pins: 1'b0, asub: AS_START, malf: 1'b0, err: ST_OK,
    held: 8'd0, held_v: 1'b0
  };

  // one result item
  typedef struct packed {
    logic       is_status;
    logic [2:0] tag;
    logic [2:0] pin;
    logic [7:0] data;
    logic       field_end;
    logic [2:0] status;
    logic       malformed;
    logic       run_last;
  } res_t;

  // base64url digit: {valid, value}
  function automatic logic [6:0] b64_decode(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5a) r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7a) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2d) r = {1'b1, 6'd62};
    else if (c == 8'h5f) r = {1'b1, 6'd63};
    return r;
  endfunction

  // expected scheme character, lower case
  function automatic logic [7:0] scheme_char(input logic [2:0] pos);
    logic [7:0] r;
    case (pos)
      3'd0: r = 8'h73;   // s
      3'd1: r = 8'h64;   // d
      3'd2: r = 8'h6e;   // n
      3'd3: r = 8'h73;   // s
      3'd4: r = 8'h3a;   // :
      3'd5: r = 8'h2f;   // /
      3'd6: r = 8'h2f;   // /
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic res_t mk_field(input logic [2:0] tag, input logic [2:0] pin,
                                    input logic [7:0] data, input logic fend);
    res_t r;
    r = '0;
    r.tag       = tag;
    r.pin       = pin;
    r.data      = data;
    r.field_end = fend;
    return r;
  endfunction

endpackage

// File: sv/dsup_step.sv
// per-character next-state and result logic of the stamp parser
module dsup_step
  import dsup_pkg::*;
#(
  parameter int MAX_PINS = 8
) (
  input  st_t        st_i,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output st_t        st_nxt,
  output res_t       res0_o,
  output res_t       res1_o,
  output logic [1:0] res_cnt_o
);

  st_t        s;
  logic [7:0] lc;
  logic [6:0] b64;
  logic [7:0] byte_d;
  logic       byte_v;
  logic [7:0] rem_dec;
  logic       rem_zero;
  logic       p0v, p1v;
  res_t       p0, p1, f0, f1, sres;
  logic [1:0] nf;
  logic [2:0] stat;

  always_comb begin
    s        = st_i;
    p0v      = 1'b0;
    p1v      = 1'b0;
    p0       = '0;
    p1       = '0;
    lc       = (ch_i >= 8'h41 && ch_i <= 8'h5a) ? 8'(ch_i + 8'd32) : ch_i;
    b64      = b64_decode(ch_i);
    rem_dec  = 8'(st_i.rem - 8'd1);
    rem_zero = (rem_dec == 8'd0);
    byte_d   = 8'd0;
    byte_v   = 1'b0;

    if (st_i.phase == PH_SCHEME) begin
      // case-insensitive prefix match
      if (lc == scheme_char(st_i.spos)) begin
        if (st_i.spos == SCHEME_LAST) begin
          s.spos  = 3'd0;
          s.phase = PH_PROTO;
        end else begin
          s.spos = 3'(st_i.spos + 3'd1);
        end
      end else begin
        s.err   = ST_BAD_SCHEME;
        s.phase = PH_FAIL;
      end
    end else if (!(st_i.phase == PH_FAIL &&
                   (st_i.err == ST_BAD_SCHEME || st_i.err == ST_BAD_B64))) begin
      if (!b64[6]) begin
        s.err   = ST_BAD_B64;
        s.phase = PH_FAIL;
      end else begin
        // base64 byte assembly, bit position follows the character count
        s.cm4   = 2'(st_i.cm4 + 2'd1);
        s.bits6 = b64[5:0];
        case (st_i.cm4)
          2'd1: begin
            byte_d = {st_i.bits6, b64[5:4]};
            byte_v = 1'b1;
          end
          2'd2: begin
            byte_d = {st_i.bits6[3:0], b64[5:2]};
            byte_v = 1'b1;
          end
          2'd3: begin
            byte_d = {st_i.bits6[1:0], b64[5:0]};
            byte_v = 1'b1;
          end
          default: begin
            byte_v = 1'b0;
          end
        endcase

        // stamp field parsing
        if (byte_v && st_i.phase != PH_FAIL && st_i.phase != PH_DONE) begin
          case (st_i.phase)
            PH_PROTO: begin
              if (byte_d == PROTO_DOH) begin
                s.phase = PH_FLAGS;
                s.rem   = 8'd8;
              end else begin
                s.err   = ST_NOT_DOH;
                s.phase = PH_FAIL;
              end
            end
            PH_FLAGS: begin
              s.rem = rem_dec;
              p0v   = 1'b1;
              p0    = mk_field(TAG_FLAGS, 3'd0, byte_d, rem_zero);
              if (rem_zero) s.phase = PH_ADDR_LEN;
            end
            PH_ADDR_LEN: begin
              s.asub   = AS_START;
              s.held_v = 1'b0;
              if (byte_d == 8'd0) begin
                s.phase = PH_PIN_LEN;
              end else begin
                s.rem   = byte_d;
                s.phase = PH_ADDR;
              end
            end
            PH_ADDR: begin
              s.rem = rem_dec;
              case (st_i.asub)
                AS_START: begin
                  if (byte_d == CH_LBRACKET) s.asub = AS_BRACKET;
                  else if (byte_d == CH_COLON) s.asub = AS_PORT;
                  else begin
                    s.asub   = AS_PLAIN;
                    s.held   = byte_d;
                    s.held_v = 1'b1;
                  end
                end
                AS_PLAIN: begin
                  p0v = st_i.held_v;
                  if (byte_d == CH_COLON) begin
                    p0       = mk_field(TAG_HOST, 3'd0, st_i.held, 1'b1);
                    s.held_v = 1'b0;
                    s.asub   = AS_PORT;
                  end else begin
                    p0       = mk_field(TAG_HOST, 3'd0, st_i.held, 1'b0);
                    s.held   = byte_d;
                    s.held_v = 1'b1;
                  end
                end
                AS_BRACKET: begin
                  p0v = st_i.held_v;
                  if (byte_d == CH_RBRACKET) begin
                    p0       = mk_field(TAG_HOST, 3'd0, st_i.held, 1'b1);
                    s.held_v = 1'b0;
                    s.asub   = AS_AFTER;
                  end else begin
                    p0       = mk_field(TAG_HOST, 3'd0, st_i.held, 1'b0);
                    s.held   = byte_d;
                    s.held_v = 1'b1;
                  end
                end
                AS_AFTER: begin
                  if (byte_d == CH_COLON) s.asub = AS_PORT;
                  else begin
                    s.malf = 1'b1;
                    s.asub = AS_SKIP;
                  end
                end
                AS_PORT: begin
                  p0v = 1'b1;
                  p0  = mk_field(TAG_PORT, 3'd0, byte_d, rem_zero);
                end
                default: begin
                  s.asub = st_i.asub;
                end
              endcase
              // end of address flushes the held host byte
              if (rem_zero) begin
                if (s.asub == AS_BRACKET) s.malf = 1'b1;
                p1v      = s.held_v;
                p1       = mk_field(TAG_HOST, 3'd0, s.held, 1'b1);
                s.held_v = 1'b0;
                s.phase  = PH_PIN_LEN;
              end
            end
            PH_PIN_LEN: begin
              if (st_i.pins >= PIN_CNT_W'(MAX_PINS)) begin
                s.err   = ST_MANY_PINS;
                s.phase = PH_FAIL;
              end else begin
                s.more_pins = byte_d[7];
                s.rem       = {1'b0, byte_d[6:0]};
                if (byte_d[6:0] == 7'd0) begin
                  s.pins  = PIN_CNT_W'(st_i.pins + 1'b1);
                  s.phase = byte_d[7] ? PH_PIN_LEN : PH_HOST_LEN;
                end else begin
                  s.phase = PH_PIN;
                end
              end
            end
            PH_PIN: begin
              s.rem = rem_dec;
              p0v   = 1'b1;
              p0    = mk_field(TAG_PIN, st_i.pins[2:0], byte_d, rem_zero);
              if (rem_zero) begin
                s.pins  = PIN_CNT_W'(st_i.pins + 1'b1);
                s.phase = st_i.more_pins ? PH_PIN_LEN : PH_HOST_LEN;
              end
            end
            PH_HOST_LEN: begin
              s.rem   = byte_d;
              s.phase = (byte_d == 8'd0) ? PH_PATH_LEN : PH_HOST;
            end
            PH_PATH_LEN: begin
              s.rem   = byte_d;
              s.phase = (byte_d == 8'd0) ? PH_DONE : PH_PATH;
            end
            PH_HOST: begin
              s.rem = rem_dec;
              p0v   = 1'b1;
              p0    = mk_field(TAG_NAME, 3'd0, byte_d, rem_zero);
              if (rem_zero) s.phase = PH_PATH_LEN;
            end
            PH_PATH: begin
              s.rem = rem_dec;
              p0v   = 1'b1;
              p0    = mk_field(TAG_PATH, 3'd0, byte_d, rem_zero);
              if (rem_zero) s.phase = PH_DONE;
            end
            default: begin
              s.phase = st_i.phase;
            end
          endcase
        end
      end
    end

    // status from the updated state
    if (s.phase == PH_SCHEME || s.err == ST_BAD_SCHEME) stat = ST_BAD_SCHEME;
    else if (s.err == ST_BAD_B64 || s.cm4 == 2'd1) stat = ST_BAD_B64;
    else if (s.err != ST_OK) stat = s.err;
    else if (s.phase != PH_DONE) stat = ST_TRUNCATED;
    else stat = ST_OK;

    sres           = '0;
    sres.is_status = 1'b1;
    sres.status    = stat;
    sres.malformed = s.malf;
    sres.run_last  = 1'b1;

    // compact field results
    f0 = p0v ? p0 : p1;
    f1 = p1;
    nf = 2'(p0v) + 2'(p1v);

    res0_o = f0;
    res1_o = f1;
    if (last_i) begin
      // a final character with two field bytes is always truncated
      if (nf == 2'd1) begin
        res1_o    = sres;
        res_cnt_o = 2'd2;
      end else begin
        res0_o    = sres;
        res_cnt_o = 2'd1;
      end
      st_nxt = ST_RESET;
    end else begin
      res_cnt_o = nf;
      if (nf == 2'd1) res0_o.run_last = 1'b1;
      if (nf == 2'd2) res1_o.run_last = 1'b1;
      st_nxt = s;
    end
  end

endmodule

// File: sv/dsup_rq.sv
// result queue: takes up to two results per cycle, hands out one while out_ready_i is high
module dsup_rq
  import dsup_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt_i,
  input  res_t       d0_i,
  input  res_t       d1_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_data_o
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  res_t          q_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          pop;
  logic [AW-1:0] wr_p1;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_r != '0);
  assign out_data_o  = q_r[rd_r];
  assign room_o      = (cnt_r <= (AW+1)'(DEPTH - 2));
  assign wr_p1       = AW'(wr_r + 1'b1);

  // pointer and fill count update
  always_comb begin
    wr_nxt  = AW'(wr_r + push_cnt_i);
    rd_nxt  = pop ? AW'(rd_r + 1'b1) : rd_r;
    cnt_nxt = (AW+1)'(cnt_r + push_cnt_i - (AW+1)'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_cnt_i != 2'd0) q_r[wr_r] <= d0_i;
    if (push_cnt_i == 2'd2) q_r[wr_p1] <= d1_i;
  end

endmodule

// File: sv/dns_stamp_url_parser.sv
// top level of the dns stamp text parser
// a result is written into the result queue when its character is accepted
// throughput: one character per cycle while each yields at most one result and
//   the receiver keeps up; a character with two results pushes both into a
//   four-entry result queue that accepts characters while two entries are free
// reset (rst_n low, synchronous) returns the parser to scheme matching and
//   empties the result queue; a final character also restarts the parser
module dns_stamp_url_parser
  import dsup_pkg::*;
#(
  parameter int MAX_PINS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // text_char
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // field_tag, pin_number, data_byte, field_end,
                                  // status_code, address_malformed, zero fill
  output logic        out_tuser,  // is_status
  output logic        out_tlast   // run_last
);

  st_t        st_r, st_nxt;
  res_t       res0, res1, res_out;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  logic       accept;

  assign accept   = in_tvalid && in_tready;
  assign push_cnt = accept ? res_cnt : 2'd0;

  // character decode and parse
  dsup_step #(
    .MAX_PINS(MAX_PINS)
  ) u_step (
    .st_i      (st_r),
    .ch_i      (in_tdata),
    .last_i    (in_tlast),
    .st_nxt    (st_nxt),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  // parser state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // result queue
  dsup_rq u_rq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_cnt_i  (push_cnt),
    .d0_i        (res0),
    .d1_i        (res1),
    .room_o      (in_tready),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (res_out)
  );

  // result packing
  assign out_tdata = {5'd0, res_out.malformed, res_out.status, res_out.field_end,
                      res_out.data, res_out.pin, res_out.tag};
  assign out_tuser = res_out.is_status;
  assign out_tlast = res_out.run_last;

endmodule

// File: tb/dns_stamp_url_parser_check.sv
// result checker for the dns stamp parser: predicts each character's results and compares
`timescale 1ns / 100ps
module dns_stamp_url_parser_check
  import dsup_pkg::*;
#(
  parameter int MAX_PINS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          error_count,
  output int          pending_cnt,
  output int          results_checked
);

  string prefix_lc = "sdns://";

  // mirrored parser state
  phase_t      ph;
  logic [2:0]  spos;
  logic [15:0] bitbuf;
  logic [3:0]  nbits;
  logic [1:0]  cm4;
  logic [7:0]  rem;
  logic [3:0]  pins;
  logic        more;
  addr_state_t asub;
  logic        malf;
  logic [2:0]  err;
  logic [7:0]  held;
  logic        held_v;

  // field results of the character in progress
  res_t step_fields[2];
  int   n_fields;

  // results still owed by the block, oldest first
  res_t expected_results[$];
  int   mismatches;
  int   compared;

  function automatic void clear_state();
    ph     = PH_SCHEME;
    spos   = 3'd0;
    bitbuf = 16'd0;
    nbits  = 4'd0;
    cm4    = 2'd0;
    rem    = 8'd0;
    pins   = 4'd0;
    more   = 1'b0;
    asub   = AS_START;
    malf   = 1'b0;
    err    = ST_OK;
    held   = 8'd0;
    held_v = 1'b0;
  endfunction

  function automatic void note_field(logic [2:0] tag, logic [2:0] pin, logic [7:0] b,
                                     logic fend);
    res_t r;
    r = '0;
    r.tag       = tag;
    r.pin       = pin;
    r.data      = b;
    r.field_end = fend;
    if (n_fields < 2) begin
      step_fields[n_fields] = r;
      n_fields++;
    end
  endfunction

  // first error sticks, parsing stops
  function automatic void raise_error(logic [2:0] code);
    if (err == ST_OK) err = code;
    ph = PH_FAIL;
  endfunction

  // host bytes go out one late so the last one can carry field_end
  function automatic void host_push(logic [7:0] b);
    if (held_v) note_field(TAG_HOST, 3'd0, held, 1'b0);
    held   = b;
    held_v = 1'b1;
  endfunction

  function automatic void host_close();
    if (held_v) note_field(TAG_HOST, 3'd0, held, 1'b1);
    held_v = 1'b0;
  endfunction

  // split of the address into host and port
  function automatic void addr_step(logic [7:0] b, logic fin);
    case (asub)
      AS_START: begin
        if (b == CH_LBRACKET) asub = AS_BRACKET;
        else if (b == CH_COLON) asub = AS_PORT;
        else begin
          asub = AS_PLAIN;
          host_push(b);
        end
      end
      AS_PLAIN: begin
        if (b == CH_COLON) begin
          host_close();
          asub = AS_PORT;
        end else host_push(b);
      end
      AS_BRACKET: begin
        if (b == CH_RBRACKET) begin
          host_close();
          asub = AS_AFTER;
        end else host_push(b);
      end
      AS_AFTER: begin
        if (b == CH_COLON) asub = AS_PORT;
        else begin
          malf = 1'b1;
          asub = AS_SKIP;
        end
      end
      AS_PORT: note_field(TAG_PORT, 3'd0, b, fin);
      default: ;
    endcase
    if (fin) begin
      if (asub == AS_BRACKET) malf = 1'b1;
      host_close();
    end
  endfunction

  function automatic void pin_done();
    pins = pins + 4'd1;
    ph = more ? PH_PIN_LEN : PH_HOST_LEN;
  endfunction

  // one decoded stamp byte
  function automatic void parse_byte(logic [7:0] b);
    case (ph)
      PH_PROTO: begin
        if (b == PROTO_DOH) begin
          ph  = PH_FLAGS;
          rem = 8'd8;
        end else raise_error(ST_NOT_DOH);
      end
      PH_FLAGS: begin
        rem = rem - 8'd1;
        note_field(TAG_FLAGS, 3'd0, b, rem == 8'd0);
        if (rem == 8'd0) ph = PH_ADDR_LEN;
      end
      PH_ADDR_LEN: begin
        asub   = AS_START;
        held_v = 1'b0;
        if (b == 8'd0) ph = PH_PIN_LEN;
        else begin
          rem = b;
          ph  = PH_ADDR;
        end
      end
      PH_ADDR: begin
        rem = rem - 8'd1;
        addr_step(b, rem == 8'd0);
        if (rem == 8'd0) ph = PH_PIN_LEN;
      end
      PH_PIN_LEN: begin
        if (pins >= MAX_PINS) raise_error(ST_MANY_PINS);
        else begin
          more = b[7];
          rem  = {1'b0, b[6:0]};
          if (rem == 8'd0) pin_done();
          else ph = PH_PIN;
        end
      end
      PH_PIN: begin
        rem = rem - 8'd1;
        note_field(TAG_PIN, pins[2:0], b, rem == 8'd0);
        if (rem == 8'd0) pin_done();
      end
      PH_HOST_LEN: begin
        rem = b;
        ph = (b == 8'd0) ? PH_PATH_LEN : PH_HOST;
      end
      PH_PATH_LEN: begin
        rem = b;
        ph = (b == 8'd0) ? PH_DONE : PH_PATH;
      end
      PH_HOST: begin
        rem = rem - 8'd1;
        note_field(TAG_NAME, 3'd0, b, rem == 8'd0);
        if (rem == 8'd0) ph = PH_PATH_LEN;
      end
      PH_PATH: begin
        rem = rem - 8'd1;
        note_field(TAG_PATH, 3'd0, b, rem == 8'd0);
        if (rem == 8'd0) ph = PH_DONE;
      end
      default: ;
    endcase
  endfunction

  // base64url digit value, -1 for anything else
  function automatic int sextet_of(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) return int'(c - 8'h41);
    if (c >= 8'h61 && c <= 8'h7a) return int'(c - 8'h61) + 26;
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30) + 52;
    if (c == 8'h2d) return 62;
    if (c == 8'h5f) return 63;
    return -1;
  endfunction

  // works out the results of one accepted character
  function automatic void predict_char(logic [7:0] c, logic fin);
    logic [7:0] lc;
    logic [2:0] st;
    int         v;
    res_t       r;
    n_fields = 0;
    if (ph == PH_SCHEME) begin
      lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
      if (lc == prefix_lc[spos]) begin
        spos = spos + 3'd1;
        if (spos == 3'd7) begin
          spos = 3'd0;
          ph   = PH_PROTO;
        end
      end else raise_error(ST_BAD_SCHEME);
    end else if (!(ph == PH_FAIL && (err == ST_BAD_SCHEME || err == ST_BAD_B64))) begin
      v = sextet_of(c);
      if (v < 0) begin
        // bad base64 overrides any earlier parse error
        err = ST_BAD_B64;
        ph  = PH_FAIL;
      end else begin
        cm4    = cm4 + 2'd1;
        bitbuf = {bitbuf[9:0], 6'(v)};
        nbits  = nbits + 4'd6;
        if (nbits >= 4'd8) begin
          nbits = nbits - 4'd8;
          if (ph != PH_FAIL && ph != PH_DONE) parse_byte(8'(bitbuf >> nbits));
        end
      end
    end
    // two field bytes on the final character: only the status goes out
    if (fin && n_fields == 2) n_fields = 0;
    for (int i = 0; i < n_fields; i++) begin
      r = step_fields[i];
      r.run_last = !fin && (i == n_fields - 1);
      expected_results.push_back(r);
    end
    if (fin) begin
      if (ph == PH_SCHEME || err == ST_BAD_SCHEME) st = ST_BAD_SCHEME;
      else if (err == ST_BAD_B64 || cm4 == 2'd1) st = ST_BAD_B64;
      else if (err != ST_OK) st = err;
      else if (ph != PH_DONE) st = ST_TRUNCATED;
      else st = ST_OK;
      r = '0;
      r.is_status = 1'b1;
      r.status    = st;
      r.malformed = malf;
      r.run_last  = 1'b1;
      expected_results.push_back(r);
      clear_state();
    end
  endfunction

  function automatic string describe(res_t r);
    return $sformatf("sts=%0b tag=%0d pin=%0d data=%02h end=%0b code=%0d malf=%0b last=%0b",
                     r.is_status, r.tag, r.pin, r.data, r.field_end, r.status, r.malformed,
                     r.run_last);
  endfunction

  // compare results first, then predict for a newly accepted character
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      clear_state();
      expected_results.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '0;
        got.is_status = out_tuser;
        got.tag       = out_tdata[2:0];
        got.pin       = out_tdata[5:3];
        got.data      = out_tdata[13:6];
        got.field_end = out_tdata[14];
        got.status    = out_tdata[17:15];
        got.malformed = out_tdata[18];
        got.run_last  = out_tlast;
        compared++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %s", $time, describe(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: result mismatch, expected %s", $time, describe(want));
            $display("%0t:                  actual   %s", $time, describe(got));
          end
        end
      end
      if (in_tvalid && in_tready) predict_char(in_tdata, in_tlast);
    end
    error_count     <= mismatches;
    pending_cnt     <= expected_results.size();
    results_checked <= compared;
  end

endmodule

// File: tb/dns_stamp_url_parser_test.sv
// testbench top for the dns stamp parser: clock, reset, stamp text stimulus and verdict
`timescale 1ns / 100ps
module dns_stamp_url_parser_test
  import dsup_pkg::*;
();

  localparam int RANDOM_CHARS = 1250;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_START   = 1200;
  localparam int HOLD_CYCLES  = 300;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BUSY} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int error_count;
  int pending_cnt;
  int results_checked;

  int chars_sent;
  int stamps_sent;
  int noise_stamps;
  int altered_stamps;
  int burst_left;

  string      b64_digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
  string      host_chars = "abcdefghijklmnopqrstuvwxyz0123456789.-";
  string      scheme_txt = "sdns://";
  logic [7:0] payload_q[$];
  logic [7:0] stamp_text[$];

  dns_stamp_url_parser #(
    .MAX_PINS(8)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  dns_stamp_url_parser_check #(
    .MAX_PINS(8)
  ) i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .error_count    (error_count),
    .pending_cnt    (pending_cnt),
    .results_checked(results_checked)
  );

  always #10 clk = ~clk;

  // one character request, held until accepted; random gaps between bursts
  task automatic send_char(input logic [7:0] c, input logic last);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                : $urandom_range(1, 30);
    end
  endtask

  task automatic send_word(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic bit is_b64_char(logic [7:0] c);
    for (int i = 0; i < 64; i++) if (b64_digits[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  // host character: mostly name-like, sometimes any byte but the separators
  function automatic logic [7:0] host_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return host_chars[$urandom_range(0, host_chars.len() - 1)];
    do c = 8'($urandom_range(0, 255));
    while (c == CH_COLON || c == CH_LBRACKET || c == CH_RBRACKET);
    return c;
  endfunction

  // builds the text of one stamp: mostly well formed, some damaged, some noise
  task automatic make_stamp();
    logic [7:0] addr[$];
    logic [7:0] c;
    int         kind, hl, pl, npins, plen, acc, nb, pos, pick;
    payload_q.delete();
    stamp_text.delete();
    // scheme with random letter case
    for (int i = 0; i < 7; i++) begin
      c = scheme_txt[i];
      if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1) == 1) c = c - 8'd32;
      stamp_text.push_back(c);
    end
    // raw noise, with or without a valid scheme in front
    if ($urandom_range(0, 19) == 0) begin
      noise_stamps++;
      if ($urandom_range(0, 1) == 0) stamp_text.delete();
      repeat ($urandom_range(1, 12)) stamp_text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    // protocol and flags
    payload_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                     : PROTO_DOH);
    repeat (8) payload_q.push_back(8'($urandom_range(0, 255)));
    // address in one of its shapes
    kind = $urandom_range(0, 8);
    hl   = $urandom_range(0, 6);
    pl   = $urandom_range(1, 5);
    case (kind)
      0: ;
      1, 2: begin
        repeat ((hl == 0) ? 1 : hl) addr.push_back(host_char());
        if (kind == 2) begin
          addr.push_back(CH_COLON);
          repeat (pl) addr.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end
      end
      3: begin
        addr.push_back(CH_COLON);
        repeat (pl) addr.push_back(8'h30 + 8'($urandom_range(0, 9)));
      end
      4, 5, 6, 7: begin
        addr.push_back(CH_LBRACKET);
        repeat (hl) addr.push_back(host_char());
        if (kind != 6) addr.push_back(CH_RBRACKET);
        if (kind == 4) begin
          addr.push_back(CH_COLON);
          repeat (pl) addr.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end
        if (kind == 7) begin
          // closing bracket followed by something other than a colon
          do c = 8'($urandom_range(0, 255));
          while (c == CH_COLON);
          addr.push_back(c);
          repeat ($urandom_range(0, 3)) addr.push_back(8'($urandom_range(0, 255)));
        end
      end
      default: repeat ($urandom_range(1, 10)) addr.push_back(8'($urandom_range(0, 255)));
    endcase
    payload_q.push_back(8'(addr.size()));
    foreach (addr[i]) payload_q.push_back(addr[i]);
    // cert pins, sometimes exactly the limit or beyond it
    pick  = $urandom_range(0, 99);
    npins = (pick < 8) ? 8 : (pick < 15) ? $urandom_range(9, 10) : $urandom_range(1, 3);
    for (int p = 0; p < npins; p++) begin
      plen = ($urandom_range(0, 49) == 0) ? 127 : $urandom_range(0, 6);
      payload_q.push_back(8'(plen) | ((p < npins - 1) ? 8'h80 : 8'h00));
      repeat (plen) payload_q.push_back(8'($urandom_range(0, 255)));
    end
    // hostname and path
    hl = ($urandom_range(0, 49) == 0) ? 255 : $urandom_range(0, 8);
    payload_q.push_back(8'(hl));
    repeat (hl) payload_q.push_back(8'($urandom_range(0, 255)));
    pl = $urandom_range(0, 6);
    payload_q.push_back(8'(pl));
    repeat (pl) payload_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 3)) payload_q.push_back(8'($urandom_range(0, 255)));
    // base64url without padding; unused trailing bits are random
    acc = 0;
    nb  = 0;
    foreach (payload_q[i]) begin
      acc = (acc << 8) | payload_q[i];
      nb += 8;
      while (nb >= 6) begin
        nb -= 6;
        stamp_text.push_back(b64_digits[(acc >> nb) & 63]);
      end
      acc &= (1 << nb) - 1;
    end
    if (nb > 0)
      stamp_text.push_back(b64_digits[((acc << (6 - nb)) |
                                       $urandom_range(0, (1 << (6 - nb)) - 1)) & 63]);
    // damage: scheme, a bad character, early end, or one extra digit
    pick = $urandom_range(0, 99);
    if (pick < 30) altered_stamps++;
    if (pick < 6) begin
      stamp_text[$urandom_range(0, 6)] = 8'($urandom_range(0, 255));
    end else if (pick < 14) begin
      do c = 8'($urandom_range(0, 255));
      while (is_b64_char(c));
      pos = $urandom_range(7, stamp_text.size() - 1);
      stamp_text[pos] = c;
    end else if (pick < 26) begin
      pos = $urandom_range(1, stamp_text.size() - 1);
      stamp_text = stamp_text[0:pos-1];
    end else if (pick < 30) begin
      stamp_text.push_back(b64_digits[$urandom_range(0, 63)]);
    end
  endtask

  // receiver: changing stall pattern plus one long hold-off
  initial begin
    int       rx_cycle;
    rx_mode_t mode;
    rx_cycle = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      mode = rx_mode_t'((rx_cycle / 300) % 4);
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES) begin
        out_tready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_tready <= 1'b1;
          RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= (rx_cycle % 5 == 0);
          default:   out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'h00;
    in_tlast   <= 1'b0;
    chars_sent = 0;
    stamps_sent = 0;
    noise_stamps = 0;
    altered_stamps = 0;
    burst_left = 20;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // short stamps: bad scheme, end after scheme, wrong protocol, one stray digit
    send_char(8'hff, 1'b1);
    send_word("sDNS://");
    send_word("sdns://AQ");
    send_word("sdns://A");

    while (chars_sent < RANDOM_CHARS + 25) begin
      make_stamp();
      foreach (stamp_text[i]) send_char(stamp_text[i], i == stamp_text.size() - 1);
      stamps_sent++;
      // now and then let the block drain completely
      if (stamps_sent % 15 == 0) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_cnt != 0) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d random stamps (%0d damaged, %0d noise) in %0d characters",
             stamps_sent, altered_stamps, noise_stamps, chars_sent);
    $display("%0d results checked against prediction", results_checked);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(CYCLE_LIMIT * 20);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
sv/dsup_pkg.sv
sv/dsup_step.sv
sv/dsup_rq.sv
sv/dns_stamp_url_parser.sv
tb/dns_stamp_url_parser_check.sv
tb/dns_stamp_url_parser_test.sv
